/* rtl/core/fbpa_pkg.sv */
package fbpa_pkg;

	localparam int MAX_BLOCKS    = 256;
	localparam int POINTER_BYTES = 8;
	localparam int LINK_DEPTH    = 256;
	localparam int IDX_W         = $clog2(LINK_DEPTH);
	localparam int CNT_W         = IDX_W + 1;
	localparam int SIZE_W        = 16;
	localparam int NORM_W        = SIZE_W + 1;
	localparam int ALIGN_W       = 4;
	localparam int OFFSET_W      = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int POOL_CAP      = (MAX_BLOCKS < LINK_DEPTH) ? MAX_BLOCKS : LINK_DEPTH;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NO_LIVE   = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 2'd2;

	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(256);
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(8);
	localparam logic [ALIGN_W-1:0] ALIGN_RST     = ALIGN_W'(3);

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] block_index;
	} cmd_t;

	typedef struct packed {
		logic                granted;
		logic [IDX_W-1:0]    out_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic [1:0]          status;
		logic [CNT_W-1:0]    live_count;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]  block_cap;
		logic [NORM_W-1:0] norm_size;
	} cfg_t;

endpackage

/* rtl/core/fbpa_link_mem.sv */
module fbpa_link_mem
	import fbpa_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0] mem [LINK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/fbpa_cfg.sv */
module fbpa_cfg
	import fbpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [CNT_W-1:0]   block_count_q;
	logic [SIZE_W-1:0]  block_size_q;
	logic [ALIGN_W-1:0] align_log2_q;
	logic [NORM_W-1:0]  size_min;
	logic [NORM_W-1:0]  align_mask;
	logic [NORM_W-1:0]  size_sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			block_size_q  <= BLOCK_SIZE_RST;
			align_log2_q  <= ALIGN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
				CFG_BLOCK_SIZE:  block_size_q  <= cfg_data[SIZE_W-1:0];
				CFG_ALIGN_LOG2:  align_log2_q  <= cfg_data[ALIGN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The block must hold at least one pointer, then it is rounded up to the alignment.
	always_comb begin
		size_min   = (block_size_q < SIZE_W'(POINTER_BYTES)) ? NORM_W'(POINTER_BYTES)
		                                                   : {1'b0, block_size_q};
		align_mask = (NORM_W'(1) << align_log2_q) - NORM_W'(1);
		size_sum   = size_min + align_mask;
		cfg.norm_size = size_sum & ~align_mask;
		cfg.block_cap = (block_count_q > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : block_count_q;
	end

endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator. Each command (allocate, free or pool reset) is
// taken whenever start is high and busy is never raised, so a command may be issued in
// every cycle; its result appears on res with done high in the cycle right after
// the command was taken, and the receiver cannot stall it. The head of the free list
// and the link below it are kept in registers, and a pop reads the following link
// from the link memory in the same cycle, so back-to-back allocations need no wait.
// New settings of block_count take effect at the next pool reset command; the size
// and alignment settings apply to the offsets of later allocations.
module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] next_q, next_d, next_eff;
	logic             refill_q, refill_d;
	logic [CNT_W-1:0] fresh_q, fresh_d;
	logic [CNT_W-1:0] live_q, live_d;
	logic [CNT_W-1:0] active_q, active_d;
	logic             done_q;
	res_t             res_q, res_d;
	logic             accept;

	logic             mem_we;
	logic [IDX_W-1:0] mem_rdata;
	logic [IDX_W-1:0] out_idx;
	logic [IDX_W+NORM_W-1:0] offset_full;

	fbpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fbpa_link_mem u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cmd.block_index),
		.wdata (head_q),
		.raddr (next_eff),
		.rdata (mem_rdata)
	);

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// After a pop the link below the new head arrives from the memory in the next cycle.
	assign next_eff = refill_q ? mem_rdata : next_q;

	always_comb begin
		head_d   = head_q;
		next_d   = next_eff;
		refill_d = 1'b0;
		fresh_d  = fresh_q;
		live_d   = live_q;
		active_d = active_q;
		mem_we   = 1'b0;
		out_idx  = '0;
		res_d    = '0;
		if (accept) begin
			case (cmd.kind)
				KIND_ALLOC: begin
					if (fresh_q > live_q) begin
						out_idx  = head_q;
						head_d   = next_eff;
						refill_d = 1'b1;
						live_d   = live_q + CNT_W'(1);
						res_d.granted = 1'b1;
					end else if (fresh_q < active_q) begin
						out_idx  = fresh_q[IDX_W-1:0];
						fresh_d  = fresh_q + CNT_W'(1);
						live_d   = live_q + CNT_W'(1);
						res_d.granted = 1'b1;
					end else begin
						res_d.status = ST_EXHAUSTED;
					end
				end
				KIND_FREE: begin
					if (live_q == '0) begin
						res_d.status = ST_NO_LIVE;
					end else if ({1'b0, cmd.block_index} >= active_q) begin
						res_d.status = ST_RANGE;
					end else begin
						mem_we = 1'b1;
						head_d = cmd.block_index;
						next_d = head_q;
						live_d = live_q - CNT_W'(1);
					end
				end
				KIND_RESET: begin
					active_d = cfg.block_cap;
					head_d   = '0;
					fresh_d  = '0;
					live_d   = '0;
				end
				default: begin
				end
			endcase
		end
		offset_full       = {{NORM_W{1'b0}}, out_idx} * {{IDX_W{1'b0}}, cfg.norm_size};
		res_d.out_index   = out_idx;
		res_d.byte_offset = offset_full[OFFSET_W-1:0];
		res_d.live_count  = live_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			next_q   <= '0;
			refill_q <= 1'b0;
			fresh_q  <= '0;
			live_q   <= '0;
			active_q <= CNT_W'(POOL_CAP);
			done_q   <= 1'b0;
		end else begin
			head_q   <= head_d;
			next_q   <= next_d;
			refill_q <= refill_d;
			fresh_q  <= fresh_d;
			live_q   <= live_d;
			active_q <= active_d;
			done_q   <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("done missing after an accepted request");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("done without an accepted request");

	a_live_within_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= fresh_q)
		else $error("more live blocks than blocks ever handed out");

	a_fresh_within_pool: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= active_q)
		else $error("fresh watermark beyond the active pool size");

	a_grant_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.granted) |-> (res.status == ST_OK))
		else $error("granted result with an error status");
`endif

endmodule
